/* hdl/tmc_pkg.sv */
// tmc_pkg: shared constants and types for the text console engine
// geometry, item kinds, control bytes, register indexes, store request bundle
// no dependencies
`default_nettype none

package tmc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    // fixed field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_SETCUR = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

`default_nettype wire

/* hdl/tmc_cell_store.sv */
// tmc_cell_store: screen cell memory, one write and one registered read per cycle
// depends on tmc_pkg
`default_nettype none

module tmc_cell_store
    import tmc_pkg::*;
(
    input  wire logic              clk,
    input  wire store_req_t        req,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/text_mode_character_console.sv */
// text_mode_character_console: console sequencer with cursor and colors
// drives the sweep counter and address unit over tmc_cell_store
// depends on tmc_pkg, tmc_cell_store
//
//   channel   signals                               timing
//   command   start, busy, kind, char_code, col, row  taken when start && !busy
//   result    done, cursor_col, cursor_row,           one cycle, no stall
//             cell_char, cell_attr
//   config    wr_en, wr_index, wr_data                written at any edge with wr_en
//
// set cursor, control bytes and printable bytes without scroll: done in the next cycle
// read cell: done after the registered memory read and S_READ; in the next cycle when out of range
// scroll: S_SCR_RD reads each cell one row below, S_SCR_WR writes it, then S_FILL blanks the bottom row
// clear screen: S_CLR writes every cell, one after another, then raises done
// after reset the store is swept to zero in S_INIT with busy high
`default_nettype none

module text_mode_character_console
    import tmc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       kind,
    input  wire logic [7:0]       char_code,
    input  wire logic [COL_W-1:0] col,
    input  wire logic [ROW_W-1:0] row,
    output logic                  done,
    output logic      [COL_W-1:0] cursor_col,
    output logic      [ROW_W-1:0] cursor_row,
    output logic      [7:0]       cell_char,
    output logic      [7:0]       cell_attr,
    input  wire logic             wr_en,
    input  wire logic             wr_index,
    input  wire logic [3:0]       wr_data
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CLR    = 3'd3;
    localparam logic [2:0] S_SCR_RD = 3'd4;
    localparam logic [2:0] S_SCR_WR = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COL_LIMIT   = (COL_W + 1)'(COLUMNS);

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [7:0]        cell_char_reg, cell_char_next;
    logic [7:0]        cell_attr_reg, cell_attr_next;
    logic              done_reg, done_next;
    logic [3:0]        fg_reg, bg_reg;

    store_req_t        req;
    logic [CELL_W-1:0] rdata;
    logic [7:0]        attr;

    // character decode
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    tab_pos;
    logic [COL_W-1:0]  ch_col;
    logic [ROW_W-1:0]  ch_row;
    logic              ch_newline;
    logic              ch_scroll;
    logic              ch_write;

    // shared address unit: row * COLUMNS + col
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [ADDR_W-1:0] cell_addr;

    tmc_cell_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign attr = {bg_reg, fg_reg};

    always_comb
    begin
        if (kind == KIND_READ)
        begin
            addr_row = row;
            addr_col = col;
        end
        else
        begin
            addr_row = cur_row_reg;
            addr_col = cur_col_reg;
        end
        cell_addr = ADDR_W'(addr_row) * ROW_STRIDE + ADDR_W'(addr_col);
    end

    always_comb
    begin
        col_inc    = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
        tab_pos    = ({1'b0, cur_col_reg} + (COL_W + 1)'(7)) & ~(COL_W + 1)'(7);
        ch_col     = cur_col_reg;
        ch_row     = cur_row_reg;
        ch_newline = 1'b0;
        ch_write   = 1'b0;
        case (char_code)
            CH_LF:
            begin
                ch_newline = 1'b1;
            end
            CH_CR:
            begin
                ch_col = '0;
            end
            CH_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    ch_col = cur_col_reg - COL_W'(1);
                end
            end
            CH_TAB:
            begin
                if (tab_pos >= COL_LIMIT)
                begin
                    ch_newline = 1'b1;
                end
                else
                begin
                    ch_col = tab_pos[COL_W-1:0];
                end
            end
            default:
            begin
                ch_write = 1'b1;
                if (col_inc >= COL_LIMIT)
                begin
                    ch_newline = 1'b1;
                end
                else
                begin
                    ch_col = col_inc[COL_W-1:0];
                end
            end
        endcase
        ch_scroll = 1'b0;
        if (ch_newline)
        begin
            ch_col = '0;
            if (cur_row_reg >= LAST_ROW)
            begin
                ch_scroll = 1'b1;
                ch_row    = LAST_ROW;
            end
            else
            begin
                ch_row = cur_row_reg + ROW_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        done_next      = 1'b0;
        req            = '0;
        case (state_reg)
            S_INIT:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = '0;
                if (idx_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cell_char_next = '0;
                    cell_attr_next = '0;
                    case (kind)
                        KIND_CHAR:
                        begin
                            req.we       = ch_write;
                            req.waddr    = cell_addr;
                            req.wdata    = {attr, char_code};
                            cur_col_next = ch_col;
                            cur_row_next = ch_row;
                            if (ch_scroll)
                            begin
                                idx_next   = '0;
                                state_next = S_SCR_RD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        KIND_SETCUR:
                        begin
                            cur_col_next = ({1'b0, col} >= COL_LIMIT) ? LAST_COL : col;
                            cur_row_next = (row > LAST_ROW) ? LAST_ROW : row;
                            done_next    = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            idx_next     = '0;
                            state_next   = S_CLR;
                        end
                        default:
                        begin
                            if (({1'b0, col} < COL_LIMIT) && (row <= LAST_ROW))
                            begin
                                req.re     = 1'b1;
                                req.raddr  = cell_addr;
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cell_char_next = rdata[7:0];
                cell_attr_next = rdata[15:8];
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_CLR:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = {attr, 8'h00};
                if (idx_reg == LAST_CELL)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SCR_RD:
            begin
                // fetch the cell one row below
                req.re     = 1'b1;
                req.raddr  = idx_reg + ROW_STRIDE;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = rdata;
                if (idx_reg == SCROLL_LAST)
                begin
                    idx_next   = BOTTOM_BASE;
                    state_next = S_FILL;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_SCR_RD;
                end
            end
            S_FILL:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = {attr, 8'h00};
                if (idx_reg == LAST_CELL)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            idx_reg     <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            done_reg    <= 1'b0;
            fg_reg      <= 4'd7;
            bg_reg      <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            done_reg    <= done_next;
            if (wr_en && (wr_index == REG_FG))
            begin
                fg_reg <= wr_data;
            end
            if (wr_en && (wr_index == REG_BG))
            begin
                bg_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_row = cur_row_reg;
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;

endmodule

`default_nettype wire
